// ----- design/fst_pkg.sv -----
// Package with shared types and codes for the flow statistics table.
package fst_pkg;

    localparam int TupleW = 104;
    localparam int LenW   = 16;
    localparam int CountW = 4;

    typedef enum logic [2:0] {
        KIND_COUNTED = 3'd0,
        KIND_NEW     = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_RECORD  = 3'd3,
        KIND_EMPTY   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CLEAR,
        ST_DUMP,
        ST_OUT
    } state_t;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        kind_t              kind;
        logic [TupleW-1:0]  tuple;
        logic [CountW-1:0]  count;
        logic [2:0]         slot;
        logic [LenW-1:0]    size;
        logic               last;
    } result_t;

endpackage

// ----- design/fst_size_mem.sv -----
// Size slot memory: one write port and one registered read port.
module fst_size_mem #(
    parameter int Depth = 64,
    parameter int AddrW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [15:0]      wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [15:0]      rdata
);

    logic [15:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/flow_stats_table_top.sv -----
// Top level of the per-flow five-tuple statistics table.
//
// Channel   Direction  tdata / tuser contents
// s_axis    in         tdata: opcode, src_ip, dst_ip, sport, dport, proto, pkt_length
// m_axis    out        tdata: rec_src_ip .. slot_size; tuser: kind; tlast: last
//
// A packet compares one stored tuple per cycle, and a new flow then clears its
// MAX_SIZES slots one per cycle. A dump handles each record in order: it addresses
// the registered memory port, then takes the read data and then presents the
// transaction, which waits for as long as the receiver stalls.
// Reset is asynchronous and active low and needs no clearing pass. The block takes
// no item until every result has been taken.
module flow_stats_table_top #(
    parameter int MAX_FLOWS = 8,
    parameter int MAX_SIZES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[0], src_ip[32:1], dst_ip[64:33], sport[80:65], dport[96:81],
    // proto[104:97], pkt_length[120:105], zero fill
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rec_src_ip[31:0], rec_dst_ip[63:32], rec_sport[79:64],
    // rec_dport[95:80], rec_proto[103:96], rec_count[107:104],
    // slot_index[110:108], slot_size[126:111], zero fill
    output logic [127:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int FW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int SW = (MAX_SIZES > 1) ? $clog2(MAX_SIZES) : 1;
    localparam int AW = FW + SW;

    fst_pkg::state_t state_reg, state_next;

    logic [MAX_FLOWS-1:0] valid_reg, valid_next;
    logic [103:0]         tuple_mem [MAX_FLOWS];
    logic [3:0]           cnt_mem [MAX_FLOWS];
    logic [FW:0]          used_reg, used_next;
    logic [3:0]           total_reg, total_next;
    logic [FW:0]          idx_reg, idx_next;
    logic [SW:0]          slot_reg, slot_next;
    logic                 phase_reg, phase_next;
    logic                 reset_total_reg, reset_total_next;
    logic [103:0]         key_reg;
    logic [15:0]          len_reg;
    fst_pkg::result_t     res_reg, res_next;
    logic                 res_load;

    logic          tup_we, cnt_we;
    logic [FW-1:0] tup_addr;
    logic [3:0]    cnt_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;
    logic [FW-1:0] cur;
    logic [3:0]    inc;
    logic          hit;

    assign cur = idx_reg[FW-1:0];
    assign hit = valid_reg[cur] && (tuple_mem[cur] == key_reg);
    assign inc = (cnt_mem[cur] == 4'd15) ? 4'd15 : cnt_mem[cur] + 4'd1;

    fst_size_mem #(.Depth(MAX_FLOWS * MAX_SIZES), .AddrW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fst_pkg::ST_IDLE;
            valid_reg       <= '0;
            used_reg        <= '0;
            total_reg       <= '0;
            idx_reg         <= '0;
            slot_reg        <= '0;
            phase_reg       <= 1'b0;
            reset_total_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            used_reg        <= used_next;
            total_reg       <= total_next;
            idx_reg         <= idx_next;
            slot_reg        <= slot_next;
            phase_reg       <= phase_next;
            reset_total_reg <= reset_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fst_pkg::ST_IDLE && s_axis_tvalid)
        begin
            key_reg <= s_axis_tdata[104:1];
            len_reg <= s_axis_tdata[120:105];
        end
        if (tup_we)
        begin
            tuple_mem[tup_addr] <= key_reg;
        end
        if (cnt_we)
        begin
            cnt_mem[tup_addr] <= cnt_wdata;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        used_next        = used_reg;
        total_next       = total_reg;
        idx_next         = idx_reg;
        slot_next        = slot_reg;
        phase_next       = phase_reg;
        reset_total_next = reset_total_reg;
        res_next         = '0;
        res_load         = 1'b0;
        tup_we           = 1'b0;
        cnt_we           = 1'b0;
        tup_addr         = cur;
        cnt_wdata        = inc;
        mem_we           = 1'b0;
        mem_waddr        = {cur, slot_reg[SW-1:0]};
        mem_wdata        = 16'd0;
        mem_raddr        = {cur, slot_reg[SW-1:0]};
        s_axis_tready    = 1'b0;

        case (state_reg)
            fst_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    idx_next = '0;
                    if (s_axis_tdata[0] == fst_pkg::OP_FLUSH)
                    begin
                        reset_total_next = 1'b0;
                        idx_next   = used_reg;
                        slot_next  = '0;
                        phase_next = 1'b0;
                        state_next = fst_pkg::ST_DUMP;
                    end
                    else
                    begin
                        state_next = fst_pkg::ST_SEARCH;
                    end
                end
            end
            fst_pkg::ST_SEARCH:
            begin
                if (idx_reg < used_reg && hit)
                begin
                    cnt_we     = 1'b1;
                    total_next = (total_reg == 4'd15) ? 4'd15 : total_reg + 4'd1;
                    if ({1'b0, inc} <= 5'(MAX_SIZES))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {cur, SW'(inc - 4'd1)};
                        mem_wdata = len_reg;
                    end
                    if ({1'b0, inc} >= 5'(MAX_SIZES) ||
                        {1'b0, total_next} >= 5'(MAX_SIZES))
                    begin
                        reset_total_next = 1'b1;
                        idx_next   = used_reg;
                        slot_next  = '0;
                        phase_next = 1'b0;
                        state_next = fst_pkg::ST_DUMP;
                    end
                    else
                    begin
                        res_load       = 1'b1;
                        res_next.kind  = fst_pkg::KIND_COUNTED;
                        res_next.count = inc;
                        res_next.last  = 1'b1;
                        state_next     = fst_pkg::ST_OUT;
                    end
                end
                else if (idx_reg + 1'b1 < used_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (used_reg >= (FW+1)'(MAX_FLOWS))
                begin
                    res_load      = 1'b1;
                    res_next.kind = fst_pkg::KIND_DROPPED;
                    res_next.last = 1'b1;
                    state_next    = fst_pkg::ST_OUT;
                end
                else
                begin
                    // Take the next free entry, store the length in its first size slot and clear the rest.
                    idx_next   = used_reg;
                    slot_next  = '0;
                    state_next = fst_pkg::ST_CLEAR;
                end
            end
            fst_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (slot_reg == '0) ? len_reg : 16'd0;
                if (slot_reg == '0)
                begin
                    tup_we    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = 4'd1;
                end
                if (slot_reg == (SW+1)'(MAX_SIZES - 1))
                begin
                    valid_next[cur] = 1'b1;
                    used_next       = used_reg + 1'b1;
                    res_load        = 1'b1;
                    res_next.kind   = fst_pkg::KIND_NEW;
                    res_next.count  = 4'd1;
                    res_next.last   = 1'b1;
                    state_next      = fst_pkg::ST_OUT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            fst_pkg::ST_DUMP:
            begin
                // First phase addresses the memory, second takes the read data.
                if (idx_reg == '0)
                begin
                    res_load      = 1'b1;
                    res_next.kind = fst_pkg::KIND_EMPTY;
                    res_next.last = 1'b1;
                    valid_next    = '0;
                    used_next     = '0;
                    if (reset_total_reg)
                    begin
                        total_next = '0;
                    end
                    state_next    = fst_pkg::ST_OUT;
                end
                else
                begin
                    mem_raddr = {FW'(idx_reg - 1'b1), slot_reg[SW-1:0]};
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        res_load       = 1'b1;
                        res_next.kind  = fst_pkg::KIND_RECORD;
                        res_next.tuple = tuple_mem[FW'(idx_reg - 1'b1)];
                        res_next.count = cnt_mem[FW'(idx_reg - 1'b1)];
                        res_next.slot  = 3'(slot_reg);
                        res_next.size  = mem_rdata;
                        res_next.last  = (idx_reg == (FW+1)'(1)) &&
                                         (slot_reg == (SW+1)'(MAX_SIZES - 1));
                        if (res_next.last)
                        begin
                            valid_next = '0;
                            used_next  = '0;
                            if (reset_total_reg)
                            begin
                                total_next = '0;
                            end
                        end
                        state_next = fst_pkg::ST_OUT;
                    end
                end
            end
            fst_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = fst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        state_next = fst_pkg::ST_DUMP;
                        if (slot_reg == (SW+1)'(MAX_SIZES - 1))
                        begin
                            slot_next = '0;
                            idx_next  = idx_reg - 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = fst_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = (state_reg == fst_pkg::ST_OUT);
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {1'b0, res_reg.size, res_reg.slot, res_reg.count,
                            res_reg.tuple[103:96], res_reg.tuple[95:80],
                            res_reg.tuple[79:64], res_reg.tuple[63:32],
                            res_reg.tuple[31:0]};

    property p_no_result_when_idle;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == fst_pkg::ST_IDLE) |-> !m_axis_tvalid;
    endproperty
    assert property (p_no_result_when_idle) else $error("result while idle");

    property p_used_bound;
        @(posedge clk) disable iff (!rst_n)
        used_reg <= (FW+1)'(MAX_FLOWS);
    endproperty
    assert property (p_used_bound) else $error("flow count beyond table");

    property p_last_clears;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast &&
         (m_axis_tuser == fst_pkg::KIND_RECORD || m_axis_tuser == fst_pkg::KIND_EMPTY))
        |-> (used_reg == '0);
    endproperty
    assert property (p_last_clears) else $error("table not cleared after dump");

endmodule
